[rtl/prbq_pkg.sv]
// ---------------------------------------------------------------------------
// prbq_pkg
// Shared types and constants of the process ready/blocked queue manager.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package prbq_pkg;

   localparam int NUM_PROCS_DEF = 32;

   // Operation codes
   typedef enum logic [2:0] {
      OP_INS_READY   = 3'd0,
      OP_INS_BLOCKED = 3'd1,
      OP_DISPATCH    = 3'd2,
      OP_WAKE        = 3'd3,
      OP_SET_STATUS  = 3'd4
   } op_type;

   // Result codes
   typedef enum logic [2:0] {
      RC_OK          = 3'd0,
      RC_ALREADY     = 3'd1,
      RC_SHUTDOWN    = 3'd2,
      RC_UNHANDLED   = 3'd3,
      RC_NOT_FOUND   = 3'd4,
      RC_BLK_EMPTY   = 3'd5,
      RC_IN_OTHER    = 3'd6
   } code_type;

   // Process status values
   localparam logic [2:0] ST_FREE    = 3'd0;
   localparam logic [2:0] ST_READY   = 3'd1;
   localparam logic [2:0] ST_RUNNING = 3'd2;
   localparam logic [2:0] ST_BLOCKED = 3'd3;
   localparam logic [2:0] ST_ZOMBIE  = 3'd4;

   // Controller to datapath
   typedef struct packed {
      logic       capture;      // take the request fields
      logic       walk_load;    // cur <= head of queue walk_q, prev <= null
      logic       walk_q;       // 0 ready, 1 blocked
      logic       walk_step;    // prev <= cur, cur <= link[cur]
      logic       link_fetch;   // cur <= link[cur]
      logic       disp_fetch;   // cur <= link[ready head], tgt <= ready head
      logic       unlink;       // drop slot id from blocked queue (cur is its successor)
      logic       append;       // append slot to queue app_q
      logic       app_q;        // 0 ready, 1 blocked
      logic       link_term;    // link[id] <= null
      logic       disp_pop;     // ready head <= cur, link[tgt] <= null
      logic       tgt_ld_id;    // tgt <= id
      logic       nst_ld;       // load pending status
      logic       nst_from_req; // pending status from request field
      logic [2:0] nst_val;      // else this value
      logic       stat_rd;      // read old status of tgt
      logic       stat_wr;      // write pending status to tgt
      logic       rsp_load;     // load output register
      logic       rsp_disp;     // output carries tgt as dispatched slot
      code_type   rsp_code;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      op_type op;
      logic   id_in_range;
      logic   cur_null;
      logic   cur_match;
      logic   rdy_null;
      logic   blk_null;
      logic   busy_zero;
      logic   out_free;
   } sts_type;

   // Free and zombie slots do not hold up shutdown
   function automatic logic is_busy(input logic [2:0] st);
      return (st != ST_FREE) && (st != ST_ZOMBIE);
   endfunction

endpackage

[rtl/prbq_ctrl.sv]
// ---------------------------------------------------------------------------
// prbq_ctrl
// Sequencer of the queue manager: decodes the operation, steers the link
// walk and the status update, and hands the result to the output stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prbq_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  prbq_pkg::sts_type sts,
   output prbq_pkg::cmd_type cmd
);
   import prbq_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE     = 10'b00_0000_0001,
      S_DECODE   = 10'b00_0000_0010,
      S_WALK     = 10'b00_0000_0100,
      S_UNLINK   = 10'b00_0000_1000,
      S_APPEND   = 10'b00_0001_0000,
      S_TERM     = 10'b00_0010_0000,
      S_DISP_POP = 10'b00_0100_0000,
      S_STAT_RD  = 10'b00_1000_0000,
      S_STAT_WR  = 10'b01_0000_0000,
      S_RESP     = 10'b10_0000_0000
   } state_type;

   state_type state_ff, state_in;
   code_type  code_ff, code_in;
   logic      pass_ff, pass_in;   // insert: 0 own queue, 1 other queue

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      cmd.rsp_code = code_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            code_in = RC_OK;
            unique case (sts.op)
               OP_INS_READY, OP_INS_BLOCKED: begin
                  if (!sts.id_in_range) begin
                     code_in  = RC_NOT_FOUND;
                     state_in = S_RESP;
                  end else begin
                     cmd.walk_load = 1'b1;
                     cmd.walk_q    = (sts.op == OP_INS_BLOCKED);
                     pass_in       = 1'b0;
                     state_in      = S_WALK;
                  end
               end
               OP_DISPATCH: begin
                  if (sts.rdy_null) begin
                     code_in  = sts.busy_zero ? RC_SHUTDOWN : RC_UNHANDLED;
                     state_in = S_RESP;
                  end else begin
                     cmd.disp_fetch = 1'b1;
                     state_in       = S_DISP_POP;
                  end
               end
               OP_WAKE: begin
                  if (sts.blk_null) begin
                     code_in  = RC_BLK_EMPTY;
                     state_in = S_RESP;
                  end else if (!sts.id_in_range) begin
                     code_in  = RC_NOT_FOUND;
                     state_in = S_RESP;
                  end else begin
                     cmd.walk_load = 1'b1;
                     cmd.walk_q    = 1'b1;
                     state_in      = S_WALK;
                  end
               end
               OP_SET_STATUS: begin
                  if (!sts.id_in_range) begin
                     code_in  = RC_NOT_FOUND;
                     state_in = S_RESP;
                  end else begin
                     cmd.tgt_ld_id    = 1'b1;
                     cmd.nst_ld       = 1'b1;
                     cmd.nst_from_req = 1'b1;
                     state_in         = S_STAT_RD;
                  end
               end
               default: begin
                  state_in = S_RESP;
               end
            endcase
         end
         S_WALK: begin
            if (sts.op == OP_WAKE) begin
               if (sts.cur_match) begin
                  cmd.link_fetch = 1'b1;
                  state_in       = S_UNLINK;
               end else if (sts.cur_null) begin
                  code_in  = RC_NOT_FOUND;
                  state_in = S_RESP;
               end else begin
                  cmd.walk_step = 1'b1;
               end
            end else begin
               if (sts.cur_match) begin
                  code_in  = pass_ff ? RC_IN_OTHER : RC_ALREADY;
                  state_in = S_RESP;
               end else if (sts.cur_null) begin
                  if (!pass_ff) begin
                     // own queue done, now look through the other one
                     cmd.walk_load = 1'b1;
                     cmd.walk_q    = (sts.op != OP_INS_BLOCKED);
                     pass_in       = 1'b1;
                  end else begin
                     state_in = S_APPEND;
                  end
               end else begin
                  cmd.walk_step = 1'b1;
               end
            end
         end
         S_UNLINK: begin
            cmd.unlink = 1'b1;
            state_in   = S_APPEND;
         end
         S_APPEND: begin
            cmd.append = 1'b1;
            cmd.app_q  = (sts.op == OP_INS_BLOCKED);
            state_in   = S_TERM;
         end
         S_TERM: begin
            cmd.link_term = 1'b1;
            cmd.tgt_ld_id = 1'b1;
            cmd.nst_ld    = 1'b1;
            cmd.nst_val   = (sts.op == OP_INS_BLOCKED) ? ST_BLOCKED : ST_READY;
            state_in      = S_STAT_RD;
         end
         S_DISP_POP: begin
            cmd.disp_pop = 1'b1;
            cmd.nst_ld   = 1'b1;
            cmd.nst_val  = ST_RUNNING;
            state_in     = S_STAT_RD;
         end
         S_STAT_RD: begin
            cmd.stat_rd = 1'b1;
            state_in    = S_STAT_WR;
         end
         S_STAT_WR: begin
            cmd.stat_wr = 1'b1;
            state_in    = S_RESP;
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_disp = (sts.op == OP_DISPATCH) && (code_ff == RC_OK);
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      code_ff <= code_in;
      pass_ff <= pass_in;
   end

endmodule

[rtl/prbq_dpath.sv]
// ---------------------------------------------------------------------------
// prbq_dpath
// Datapath of the queue manager: link and status memories, queue heads and
// tails, walk pointers, busy count and the output register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module prbq_dpath #(
   parameter int NUM_PROCS = prbq_pkg::NUM_PROCS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        req_op,
   input  logic [4:0]        req_proc_id,
   input  logic [2:0]        req_new_status,
   input  logic              rsp_stall,
   output logic              rsp_valid,
   output logic [4:0]        rsp_dispatched_id,
   output logic [2:0]        rsp_code,
   input  prbq_pkg::cmd_type cmd,
   output prbq_pkg::sts_type sts
);
   import prbq_pkg::*;

   localparam int LINK_W = $clog2(NUM_PROCS + 1);
   localparam int IDX_W  = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
   localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_PROCS);

   // request
   logic [2:0] op_ff;
   logic [4:0] id_ff;
   logic [2:0] ns_ff;

   // queue pointers and walk registers
   logic [LINK_W-1:0] rdy_head_ff, rdy_head_in, blk_head_ff, blk_head_in;
   logic [LINK_W-1:0] rdy_tail_ff, blk_tail_ff;
   logic [LINK_W-1:0] cur_ff, prev_ff, tgt_ff;

   // status update
   logic [2:0]        nst_ff, stat_old_ff;
   logic              stat_old_vld_ff;
   logic [LINK_W-1:0] busy_cnt_ff, busy_cnt_in;
   logic [NUM_PROCS-1:0] stat_vld_ff;

   // memories
   logic [LINK_W-1:0] link_mem [NUM_PROCS];
   logic [2:0]        stat_mem [NUM_PROCS];

   // output stage
   logic       rsp_valid_ff;
   logic [4:0] rsp_id_ff;
   logic [2:0] rsp_code_ff;

   logic [LINK_W-1:0] id_link;
   logic              id_in_range;
   logic              prev_null;
   logic              app_head_null;
   logic [LINK_W-1:0] app_tail;
   logic              lnk_rd_en;
   logic [IDX_W-1:0]  lnk_rd_addr;
   logic              lnk_we;
   logic [IDX_W-1:0]  lnk_wa;
   logic [LINK_W-1:0] lnk_wd;
   logic [IDX_W-1:0]  tgt_idx;
   logic              old_busy, new_busy;

   assign id_link       = LINK_W'(id_ff);
   assign id_in_range   = (32'(id_ff) < 32'(NUM_PROCS));
   assign prev_null     = (prev_ff == NULL_LINK);
   assign app_head_null = cmd.app_q ? (blk_head_ff == NULL_LINK) : (rdy_head_ff == NULL_LINK);
   assign app_tail      = cmd.app_q ? blk_tail_ff : rdy_tail_ff;
   assign tgt_idx       = tgt_ff[IDX_W-1:0];

   assign lnk_rd_en   = cmd.walk_step | cmd.link_fetch | cmd.disp_fetch;
   assign lnk_rd_addr = cmd.disp_fetch ? rdy_head_ff[IDX_W-1:0] : cur_ff[IDX_W-1:0];

   // one link write per cycle; commands never overlap
   always_comb begin
      lnk_we = 1'b0;
      lnk_wa = '0;
      lnk_wd = NULL_LINK;
      if (cmd.unlink && !prev_null) begin
         lnk_we = 1'b1;
         lnk_wa = prev_ff[IDX_W-1:0];
         lnk_wd = cur_ff;
      end else if (cmd.append && !app_head_null) begin
         lnk_we = 1'b1;
         lnk_wa = app_tail[IDX_W-1:0];
         lnk_wd = id_link;
      end else if (cmd.link_term) begin
         lnk_we = 1'b1;
         lnk_wa = id_link[IDX_W-1:0];
      end else if (cmd.disp_pop) begin
         lnk_we = 1'b1;
         lnk_wa = tgt_idx;
      end
   end

   // queue heads
   always_comb begin
      rdy_head_in = rdy_head_ff;
      blk_head_in = blk_head_ff;
      if (cmd.unlink && prev_null) begin
         blk_head_in = cur_ff;
      end
      if (cmd.append && app_head_null) begin
         if (cmd.app_q) begin
            blk_head_in = id_link;
         end else begin
            rdy_head_in = id_link;
         end
      end
      if (cmd.disp_pop) begin
         rdy_head_in = cur_ff;
      end
   end

   // busy count follows every status write
   assign old_busy = stat_old_vld_ff && is_busy(stat_old_ff);
   assign new_busy = is_busy(nst_ff);

   always_comb begin
      busy_cnt_in = busy_cnt_ff;
      if (cmd.stat_wr) begin
         if (new_busy && !old_busy) begin
            busy_cnt_in = busy_cnt_ff + LINK_W'(1);
         end else if (old_busy && !new_busy) begin
            busy_cnt_in = busy_cnt_ff - LINK_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rdy_head_ff  <= NULL_LINK;
         blk_head_ff  <= NULL_LINK;
         busy_cnt_ff  <= '0;
         stat_vld_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rdy_head_ff <= rdy_head_in;
         blk_head_ff <= blk_head_in;
         busy_cnt_ff <= busy_cnt_in;
         if (cmd.stat_wr) begin
            stat_vld_ff[tgt_idx] <= 1'b1;
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // link memory and walk pointers
   always_ff @(posedge clock) begin
      if (lnk_we) begin
         link_mem[lnk_wa] <= lnk_wd;
      end
      if (cmd.walk_load) begin
         cur_ff  <= cmd.walk_q ? blk_head_ff : rdy_head_ff;
         prev_ff <= NULL_LINK;
      end else if (lnk_rd_en) begin
         cur_ff <= link_mem[lnk_rd_addr];
         if (cmd.walk_step) begin
            prev_ff <= cur_ff;
         end
      end
   end

   // status memory
   always_ff @(posedge clock) begin
      if (cmd.stat_wr) begin
         stat_mem[tgt_idx] <= nst_ff;
      end
      if (cmd.stat_rd) begin
         stat_old_ff     <= stat_mem[tgt_idx];
         stat_old_vld_ff <= stat_vld_ff[tgt_idx];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff <= req_op;
         id_ff <= req_proc_id;
         ns_ff <= req_new_status;
      end
      if (cmd.append) begin
         if (cmd.app_q) begin
            blk_tail_ff <= id_link;
         end else begin
            rdy_tail_ff <= id_link;
         end
      end
      if (cmd.unlink && (blk_tail_ff == id_link)) begin
         blk_tail_ff <= prev_ff;
      end
      if (cmd.tgt_ld_id) begin
         tgt_ff <= id_link;
      end else if (cmd.disp_fetch) begin
         tgt_ff <= rdy_head_ff;
      end
      if (cmd.nst_ld) begin
         nst_ff <= cmd.nst_from_req ? ns_ff : cmd.nst_val;
      end
      if (cmd.rsp_load) begin
         rsp_id_ff   <= cmd.rsp_disp ? 5'(tgt_ff) : 5'd0;
         rsp_code_ff <= cmd.rsp_code;
      end
   end

   assign sts.op          = op_type'(op_ff);
   assign sts.id_in_range = id_in_range;
   assign sts.cur_null    = (cur_ff == NULL_LINK);
   assign sts.cur_match   = id_in_range && (cur_ff == id_link);
   assign sts.rdy_null    = (rdy_head_ff == NULL_LINK);
   assign sts.blk_null    = (blk_head_ff == NULL_LINK);
   assign sts.busy_zero   = (busy_cnt_ff == '0);
   assign sts.out_free    = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_dispatched_id = rsp_id_ff;
   assign rsp_code          = rsp_code_ff;

   // queues never share their head
   assert property (@(posedge clock) disable iff (reset)
      (rdy_head_ff != NULL_LINK) |-> (rdy_head_ff != blk_head_ff))
      else $error("ready and blocked queues share a head");

   // busy count cannot exceed the slot count
   assert property (@(posedge clock) disable iff (reset)
      busy_cnt_ff <= LINK_W'(NUM_PROCS))
      else $error("busy count overflow");

   // a walk step never follows a null link
   assert property (@(posedge clock) disable iff (reset)
      (cmd.walk_step || cmd.link_fetch) |-> (cur_ff != NULL_LINK))
      else $error("link walk past the tail");

   // a result is never loaded over one still waiting
   assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten");

endmodule

[rtl/process_ready_block_queue_manager.sv]
// ---------------------------------------------------------------------------
// process_ready_block_queue_manager
// Keeps a status for every process slot and two FIFO queues, ready and
// blocked, chained through one next-link per slot. Each request item carries
// one operation (insert ready, insert blocked, dispatch, wake, set status)
// and gives exactly one result item with the dispatched slot and a code.
// Items are handled one at a time; req_stall is low only while the block is
// idle. Insert walks both queues for the duplicate check, wake walks the
// blocked queue; the link walk reads the link memory once a cycle.
// A finished result sits in an output register, so the next item may be
// taken while it waits on rsp_stall; an item that finishes while the
// previous result is still held waits in the result state until that one
// is taken. No clearing pass is needed after reset: slot status is tracked
// by per-slot valid bits.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module process_ready_block_queue_manager #(
   parameter int NUM_PROCS = prbq_pkg::NUM_PROCS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_op,
   input  logic [4:0] req_proc_id,
   input  logic [2:0] req_new_status,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [4:0] rsp_dispatched_id,
   output logic [2:0] rsp_code
);
   import prbq_pkg::*;

   // command and status between sequencer and datapath
   cmd_type cmd;
   sts_type sts;

   // Sequencer: one state per step of an operation. The walk state loops
   // once per link visited; insert walks its own queue, then the other one.
   prbq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Datapath: link memory (one read and one write a cycle), status memory
   // with valid bits, queue heads and tails, busy count for the shutdown
   // check, and the output register.
   prbq_dpath #(
      .NUM_PROCS (NUM_PROCS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .req_op            (req_op),
      .req_proc_id       (req_proc_id),
      .req_new_status    (req_new_status),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_dispatched_id (rsp_dispatched_id),
      .rsp_code          (rsp_code),
      .cmd               (cmd),
      .sts               (sts)
   );

endmodule
